/* src/preemptive_priority_scheduler_macros.svh */
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by modules that carry assertions.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pps_pkg.sv */
// Types and constants for the preemptive priority scheduler.
// No dependencies.
package pps_pkg;

  localparam int SLOT_W     = 4;
  localparam int ID_W       = 16;
  localparam int PRIO_W     = 8;
  localparam int OUT_TIME_W = 16;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       task_id;
    logic [OUT_TIME_W-1:0] arrival_time;
    logic [OUT_TIME_W-1:0] service_time;
    logic [PRIO_W-1:0]     task_priority;
  } req_t;

  typedef struct packed {
    logic                  served_valid;
    logic [SLOT_W-1:0]     served_slot;
    logic                  completed;
    logic [ID_W-1:0]       done_id;
    logic [OUT_TIME_W-1:0] departure_time;
    logic [OUT_TIME_W-1:0] turnaround;
    logic                  all_done;
    logic [OUT_TIME_W-1:0] time_now;
  } rsp_t;

  // Scan status from the pick unit.
  typedef struct packed {
    logic have_best;
    logic seen_one;
    logic seen_two;
  } scan_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

/* src/pps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pps_pick.sv */
// Shared compare unit: walks slot rows one per cycle, keeps the best ready task.
// Depends on pps_pkg.
module pps_pick #(
  parameter int IDX_W  = 4,
  parameter int TIME_W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        eval,
  input  logic                        slot_live,
  input  logic [IDX_W-1:0]            idx,
  input  logic [pps_pkg::ID_W-1:0]    id,
  input  logic [TIME_W-1:0]           arr,
  input  logic [TIME_W-1:0]           rem,
  input  logic [pps_pkg::PRIO_W-1:0]  prio,
  input  logic [TIME_W-1:0]           now,
  output pps_pkg::scan_flags_t        flags,
  output logic [IDX_W-1:0]            best_idx,
  output logic [pps_pkg::ID_W-1:0]    best_id,
  output logic [TIME_W-1:0]           best_arr,
  output logic [TIME_W-1:0]           best_rem,
  output logic [pps_pkg::PRIO_W-1:0]  best_prio
);

  logic ready;
  logic better;

  // strict > keeps the lowest slot on a priority tie
  assign ready  = eval && slot_live && (arr <= now);
  assign better = ready && (!flags.have_best || (prio > best_prio));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (eval && slot_live) begin
      flags.seen_one <= 1'b1;
      if (flags.seen_one) begin
        flags.seen_two <= 1'b1;
      end
      if (better) begin
        flags.have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx  <= idx;
      best_id   <= id;
      best_arr  <= arr;
      best_rem  <= rem;
      best_prio <= prio;
    end
  end

endmodule

/* src/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler, top level.
// Load and clear transactions complete in the accept cycle, and the block stays ready for more.
// A tick transaction runs in order: one read issue per slot on the table RAM read port,
// the last read, the pick settling on the last row, then the writeback to table and result.
// The next request is accepted once the writeback is done, later while the result is stalled.
// Synchronous reset empties all slots (valid bits) and zeroes the tick counter.
`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler #(
  parameter int SLOTS      = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pps_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pps_pkg::rsp_t rsp
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  // Table row: {id, arrival, remaining, priority}
  localparam int ROW_W = pps_pkg::ID_W + 2 * TIME_WIDTH + pps_pkg::PRIO_W;

  pps_pkg::state_t state, state_next;

  // Sequencer and scan pipeline
  logic [CNT_W-1:0]      cnt;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;
  logic                  scan_issue;

  // A slot is live while it still needs service; dead slots read as empty.
  logic [SLOTS-1:0]      valid;
  logic [TIME_WIDTH-1:0] tick;

  logic                  req_acc;
  logic                  scan_start;
  logic                  upd_fire;
  logic                  load_ok;
  logic [TIME_WIDTH-1:0] load_rem;

  // Table RAM ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      ram_rdata;

  // Fields of the row under evaluation
  logic [pps_pkg::ID_W-1:0]   row_id;
  logic [TIME_WIDTH-1:0]      row_arr;
  logic [TIME_WIDTH-1:0]      row_rem;
  logic [pps_pkg::PRIO_W-1:0] row_prio;

  // Pick unit results
  pps_pkg::scan_flags_t       flags;
  logic [IDX_W-1:0]           best_idx;
  logic [pps_pkg::ID_W-1:0]   best_id;
  logic [TIME_WIDTH-1:0]      best_arr;
  logic [TIME_WIDTH-1:0]      best_rem;
  logic [pps_pkg::PRIO_W-1:0] best_prio;

  // Writeback arithmetic
  logic [TIME_WIDTH-1:0] new_rem;
  logic                  done;
  logic [TIME_WIDTH-1:0] tick_inc;
  logic [TIME_WIDTH-1:0] turn;
  pps_pkg::rsp_t         rsp_next;

  assign req_acc  = req_valid && !req_stall;
  assign load_ok  = (32'(req.slot) < 32'(SLOTS));
  assign load_rem = TIME_WIDTH'(req.service_time);

  assign {row_id, row_arr, row_rem, row_prio} = ram_rdata;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      pps_pkg::ST_IDLE: begin
        if (scan_start) begin
          state_next = pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        // all reads issued and the last row evaluated
        if (!scan_issue && !pend) begin
          state_next = pps_pkg::ST_UPDATE;
        end
      end
      pps_pkg::ST_UPDATE: begin
        if (upd_fire) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    req_stall  = 1'b1;
    scan_start = 1'b0;
    scan_issue = 1'b0;
    upd_fire   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = IDX_W'(req.slot);
    ram_wdata  = {req.task_id, TIME_WIDTH'(req.arrival_time), load_rem, req.task_priority};
    case (state)
      pps_pkg::ST_IDLE: begin
        req_stall  = 1'b0;
        scan_start = req_valid && (req.req_type == pps_pkg::REQ_TICK);
        // loads go straight into the table
        ram_we     = req_valid && (req.req_type == pps_pkg::REQ_LOAD) && load_ok;
      end
      pps_pkg::ST_SCAN: begin
        scan_issue = (cnt < CNT_W'(SLOTS));
      end
      pps_pkg::ST_UPDATE: begin
        // hold until the output register can take the result
        upd_fire  = !rsp_valid || !rsp_stall;
        ram_we    = upd_fire && flags.have_best;
        ram_waddr = best_idx;
        ram_wdata = {best_id, best_arr, new_rem, best_prio};
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // ---------------- writeback arithmetic ----------------
  assign new_rem  = best_rem - TIME_WIDTH'(1);
  assign done     = flags.have_best && (new_rem == '0);
  assign tick_inc = (tick == '1) ? tick : tick + TIME_WIDTH'(1);
  assign turn     = tick_inc - best_arr;

  always_comb begin
    rsp_next                = '0;
    rsp_next.served_valid   = flags.have_best;
    rsp_next.served_slot    = flags.have_best ? pps_pkg::SLOT_W'(best_idx) : '0;
    rsp_next.completed      = done;
    rsp_next.done_id        = done ? best_id : '0;
    rsp_next.departure_time = done ? pps_pkg::OUT_TIME_W'(tick_inc) : '0;
    rsp_next.turnaround     = done ? pps_pkg::OUT_TIME_W'(turn) : '0;
    // empty after this tick: nothing live, or only the served slot and it just finished
    rsp_next.all_done       = !flags.seen_one || (!flags.seen_two && done);
    rsp_next.time_now       = pps_pkg::OUT_TIME_W'(tick_inc);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pps_pkg::ST_IDLE;
      valid     <= '0;
      tick      <= '0;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;

      if (req_acc && (req.req_type == pps_pkg::REQ_CLEAR)) begin
        valid <= '0;
        tick  <= '0;
      end else if (req_acc && (req.req_type == pps_pkg::REQ_LOAD) && load_ok) begin
        valid[IDX_W'(req.slot)] <= (load_rem != '0);
      end else if (upd_fire) begin
        tick <= tick_inc;
        if (done) begin
          valid[best_idx] <= 1'b0;
        end
      end

      if (scan_start) begin
        cnt  <= '0;
        pend <= 1'b0;
      end else if (state == pps_pkg::ST_SCAN) begin
        pend <= scan_issue;
        if (scan_issue) begin
          cnt <= cnt + CNT_W'(1);
        end
      end

      if (upd_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      pend_idx <= cnt[IDX_W-1:0];
    end
    if (upd_fire) begin
      rsp <= rsp_next;
    end
  end

  // ---------------- table and pick unit ----------------
  pps_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  pps_pick #(
    .IDX_W  (IDX_W),
    .TIME_W (TIME_WIDTH)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .eval      (pend),
    .slot_live (valid[pend_idx]),
    .idx       (pend_idx),
    .id        (row_id),
    .arr       (row_arr),
    .rem       (row_rem),
    .prio      (row_prio),
    .now       (tick),
    .flags     (flags),
    .best_idx  (best_idx),
    .best_id   (best_id),
    .best_arr  (best_arr),
    .best_rem  (best_rem),
    .best_prio (best_prio)
  );

  // ---------------- assertions ----------------
  `PPS_ASSERT_NXT(a_tick_starts_scan, clk, rst, req_acc && (req.req_type == pps_pkg::REQ_TICK), state == pps_pkg::ST_SCAN, "accepted tick did not start a scan")
  `PPS_ASSERT_IMP(a_rsp_from_update, clk, rst, $rose(rsp_valid), $past(state) == pps_pkg::ST_UPDATE, "result appeared outside writeback")
  `PPS_ASSERT_IMP(a_done_needs_serve, clk, rst, rsp_valid && rsp.completed, rsp.served_valid, "completion without a served task")
  `PPS_ASSERT_IMP(a_best_is_live, clk, rst, (state == pps_pkg::ST_UPDATE) && flags.have_best, valid[best_idx] && (best_rem != '0), "picked slot is not live")
  `PPS_ASSERT_NXT(a_tick_monotonic, clk, rst, !$past(rst) && !(req_acc && (req.req_type == pps_pkg::REQ_CLEAR)), tick >= $past(tick), "tick counter went backward")

endmodule
